/* hdl/lm3_pkg.sv */
`default_nettype none

package lm3_pkg;

   // Sizes of the raster and of the pixel word
   localparam int PIXEL_BITS  = 16;
   localparam int LINE_DEPTH  = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int COL_BITS    = 10;
   localparam int ROW_BITS    = 10;
   localparam int CSR_BITS    = 11;
   localparam int CSR_IDX_BITS = 1;
   localparam int RUN_MAX     = 4;
   localparam int RUN_CNT_BITS = 3;
   localparam int RSP_DATA_BITS = 24;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

   typedef logic signed [PIXEL_BITS-1:0] pixel_type;

   // One line-store entry: the row two above and the row above
   typedef struct packed {
      pixel_type upper;
      pixel_type lower;
   } line_word_type;

   // Position of a pixel and the frame-edge flags derived from it
   typedef struct packed {
      logic [ROW_BITS-1:0] row;
      logic [COL_BITS-1:0] col;
      logic                row_ge1;
      logic                row_ge2;
      logic                col_ge1;
      logic                col_ge2;
      logic                last_row;
      logic                last_col;
   } pos_type;

   // One decided pixel
   typedef struct packed {
      logic [ROW_BITS-1:0] row;
      logic [COL_BITS-1:0] col;
      logic                is_max;
   } result_type;

   // All pixels decided by one input, packed from slot 0
   typedef struct packed {
      result_type [RUN_MAX-1:0] item;
      logic [RUN_CNT_BITS-1:0]  count;
   } run_type;

endpackage

`default_nettype wire

/* hdl/lm3_line_ram.sv */
`default_nettype none

module lm3_line_ram
   import lm3_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          rd_en,
   input  wire logic [$clog2(LINE_DEPTH)-1:0] rd_addr,
   output      line_word_type                 rd_data,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(LINE_DEPTH)-1:0] wr_addr,
   input  wire line_word_type                 wr_data
);

   line_word_type mem_ff [LINE_DEPTH];
   line_word_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/lm3_window.sv */
`default_nettype none

module lm3_window
   import lm3_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      load,
   input  wire pixel_type up_px,
   input  wire pixel_type lo_px,
   input  wire pixel_type new_px,
   input  wire pos_type   pos,
   output      run_type   run
);

   pixel_type win_ff [3][3];
   pixel_type win_in [3][3];
   logic [2:0] row_ok;
   logic [2:0] col_ok;
   logic [RUN_MAX-1:0] cand_en;
   result_type cand [RUN_MAX];

   // Window after the shift: column 2 takes the new column
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_in[i][0] = win_ff[i][1];
         win_in[i][1] = win_ff[i][2];
      end
      win_in[0][2] = up_px;
      win_in[1][2] = lo_px;
      win_in[2][2] = new_px;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (load) begin
         win_ff <= win_in;
      end
   end

   // Window rows and columns that lie inside the frame
   assign row_ok = {1'b1, pos.row_ge1, pos.row_ge2};
   assign col_ok = {1'b1, pos.col_ge1, pos.col_ge2};

   // Candidates in raster order: above-left, above, left, current
   assign cand_en[0] = pos.row_ge1 & pos.col_ge1;
   assign cand_en[1] = pos.row_ge1 & pos.last_col;
   assign cand_en[2] = pos.last_row & pos.col_ge1;
   assign cand_en[3] = pos.last_row & pos.last_col;

   // Strict comparison of each candidate against its in-frame neighbours
   always_comb begin
      int wr;
      int wc;
      logic win;
      for (int k = 0; k < RUN_MAX; k++) begin
         wr = 1 + k / 2;
         wc = 1 + k % 2;
         win = 1'b1;
         for (int nr = 0; nr < 3; nr++) begin
            for (int nc = 0; nc < 3; nc++) begin
               if ((nr >= wr - 1) && (nr <= wr + 1) && (nc >= wc - 1) && (nc <= wc + 1)
                   && !((nr == wr) && (nc == wc)) && row_ok[nr] && col_ok[nc]) begin
                  if (win_in[nr][nc] >= win_in[wr][wc]) begin
                     win = 1'b0;
                  end
               end
            end
         end
         cand[k].row    = (wr == 1) ? pos.row - ROW_BITS'(1) : pos.row;
         cand[k].col    = (wc == 1) ? pos.col - COL_BITS'(1) : pos.col;
         cand[k].is_max = win;
      end
   end

   // Pack the enabled candidates from slot 0
   always_comb begin
      logic [RUN_CNT_BITS-1:0] slot;
      slot = '0;
      run  = '0;
      for (int k = 0; k < RUN_MAX; k++) begin
         if (cand_en[k]) begin
            run.item[slot[RUN_CNT_BITS-2:0]] = cand[k];
            slot = slot + RUN_CNT_BITS'(1);
         end
      end
      run.count = slot;
   end

endmodule

`default_nettype wire

/* hdl/lm3_rsp_queue.sv */
`default_nettype none

module lm3_rsp_queue
   import lm3_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     load,
   input  wire run_type                  run,
   output      logic                     load_ok,
   output      logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   output      logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output      logic                     rsp_tlast
);

   result_type              item_ff [RUN_MAX];
   logic [RUN_CNT_BITS-1:0] count_ff;
   logic                    take;

   assign take = rsp_tvalid & rsp_tready;

   // A new run may enter once the last result of the previous one leaves
   assign load_ok = (count_ff == '0) || ((count_ff == RUN_CNT_BITS'(1)) && rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (load) begin
         count_ff <= run.count;
      end else if (take) begin
         count_ff <= count_ff - RUN_CNT_BITS'(1);
      end
   end

   // Results drain from slot 0
   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < RUN_MAX; i++) begin
            item_ff[i] <= run.item[i];
         end
      end else if (take) begin
         for (int i = 0; i < RUN_MAX - 1; i++) begin
            item_ff[i] <= item_ff[i+1];
         end
      end
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tlast  = (count_ff == RUN_CNT_BITS'(1));
   assign rsp_tdata  = {{(RSP_DATA_BITS - ROW_BITS - COL_BITS - 1){1'b0}},
                        item_ff[0].is_max, item_ff[0].col, item_ff[0].row};

endmodule

`default_nettype wire

/* hdl/local_maximum_3x3_detector_core.sv */
// 3x3 local-maximum detector.
// req_* carries one signed pixel per transaction in row-major order.
// rsp_* carries one transaction per decided pixel: its row, column and
// whether it is strictly greater than all of its in-frame neighbours;
// rsp_tlast marks the final result caused by one input pixel.
// csr_* writes frame_width (index 0) and frame_height (index 1); write
// them only while the block is idle.
// Throughput: one pixel per cycle while rsp_tready is high and each pixel
// yields at most one result; a pixel at the end of a row or in the last
// row yields up to two and the last pixel of a frame up to four, and the
// single result port then holds req_tready low until the extra results
// have left. The line store is one read and one write per pixel, with a
// bypass when a pixel reads the column that is written in the same cycle.
// Reset clears counters, window and queue and sets a 4x3 frame; the line
// store is not cleared, as the window never uses unwritten entries.
// When rsp_tready is low the result queue holds, then the window stage,
// and req_tready falls.
`default_nettype none

module local_maximum_3x3_detector_core
   import lm3_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output      logic                     req_tready,
   input  wire logic [PIXEL_BITS-1:0]    req_tdata,   // [15:0] pixel_value
   output      logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   output      logic [RSP_DATA_BITS-1:0] rsp_tdata,   // [9:0] out_row, [19:10] out_col,
                                                      // [20] is_local_max, zero above
   output      logic                     rsp_tlast,   // last_of_run
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_BITS-1:0]      csr_wdata
);

   logic [CSR_BITS-1:0] width_ff;
   logic [CSR_BITS-1:0] height_ff;
   logic [COL_BITS-1:0] col_last;
   logic [ROW_BITS-1:0] row_last;
   logic [COL_BITS-1:0] col_ff;
   logic [ROW_BITS-1:0] row_ff;
   pos_type             pos_in;
   logic                accept;

   logic                s1_valid_ff;
   pixel_type           s1_px_ff;
   pos_type             s1_pos_ff;
   logic                s1_fwd_ff;
   line_word_type       s1_fwd_data_ff;
   logic                s1_fire;

   line_word_type       ram_rd_data;
   line_word_type       line_word;
   line_word_type       wr_word;
   run_type             run;
   logic                load_ok;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CSR_BITS'(4);
         height_ff <= CSR_BITS'(3);
      end else if (csr_we) begin
         case (csr_index)
            REG_FRAME_WIDTH:  width_ff  <= csr_wdata;
            REG_FRAME_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Last column and row, zero taken as one and oversize as the maximum
   always_comb begin
      if (width_ff == '0) begin
         col_last = '0;
      end else if (width_ff >= CSR_BITS'(LINE_DEPTH)) begin
         col_last = COL_BITS'(LINE_DEPTH - 1);
      end else begin
         col_last = COL_BITS'(width_ff - CSR_BITS'(1));
      end
      if (height_ff == '0) begin
         row_last = '0;
      end else if (height_ff >= CSR_BITS'(MAX_HEIGHT)) begin
         row_last = ROW_BITS'(MAX_HEIGHT - 1);
      end else begin
         row_last = ROW_BITS'(height_ff - CSR_BITS'(1));
      end
   end

   // Handshake of the window stage
   assign s1_fire    = s1_valid_ff & load_ok;
   assign req_tready = ~s1_valid_ff | s1_fire;
   assign accept     = req_tvalid & req_tready;

   // Position of the incoming pixel
   always_comb begin
      pos_in.row      = row_ff;
      pos_in.col      = col_ff;
      pos_in.row_ge1  = (row_ff != '0);
      pos_in.row_ge2  = (row_ff > ROW_BITS'(1));
      pos_in.col_ge1  = (col_ff != '0);
      pos_in.col_ge2  = (col_ff > COL_BITS'(1));
      pos_in.last_row = (row_ff >= row_last);
      pos_in.last_col = (col_ff >= col_last);
   end

   // Raster counters
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (pos_in.last_col) begin
            col_ff <= '0;
            row_ff <= pos_in.last_row ? '0 : row_ff + ROW_BITS'(1);
         end else begin
            col_ff <= col_ff + COL_BITS'(1);
         end
      end
   end

   // Window stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // Window stage payload, with bypass when the column just written is read
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff       <= req_tdata;
         s1_pos_ff      <= pos_in;
         s1_fwd_ff      <= s1_fire && (s1_pos_ff.col == col_ff);
         s1_fwd_data_ff <= wr_word;
      end
   end

   assign line_word     = s1_fwd_ff ? s1_fwd_data_ff : ram_rd_data;
   assign wr_word.upper = line_word.lower;
   assign wr_word.lower = s1_px_ff;

   lm3_line_ram u_line_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data),
      .wr_en   (s1_fire),
      .wr_addr (s1_pos_ff.col),
      .wr_data (wr_word)
   );

   lm3_window u_window (
      .clock  (clock),
      .reset  (reset),
      .load   (s1_fire),
      .up_px  (line_word.upper),
      .lo_px  (line_word.lower),
      .new_px (s1_px_ff),
      .pos    (s1_pos_ff),
      .run    (run)
   );

   lm3_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (s1_fire),
      .run        (run),
      .load_ok    (load_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
